// ----- hdl/uem_pkg.sv -----
`default_nettype none
package uem_pkg;

  // longest row the run length is sized for
  localparam int unsigned MAX_ROW_UNITS = 65536;
  localparam int unsigned LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_ROW_UNITS < 32'h1FFFF) ? LEN_W'(MAX_ROW_UNITS) : 17'h1FFFF;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;

  // one classified step: at most one kind of run event per step
  typedef struct packed {
    logic        brk;    // non-emoji code point seen
    logic        emo;    // emoji surrogate pair seen (two units)
    logic        last;   // row ends on this step
    logic [15:0] start;  // unit position of the pair's high surrogate
  } ev_t;

endpackage
`default_nettype wire

// ----- hdl/uem_front.sv -----
`default_nettype none
module uem_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // code_unit[15:0]
  input  wire logic        in_tlast,   // row_end
  input  wire logic        q_full,
  output logic             q_push,
  output uem_pkg::ev_t     q_ev
);

  logic        held_r, held_nxt;
  logic [9:0]  hi_r, hi_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        accept;
  logic        is_high, is_low;
  logic [20:0] cp;
  logic        cp_emoji;
  uem_pkg::ev_t ev;

  function automatic logic emoji_cp(input logic [20:0] c);
    return (c >= 21'h1F000 && c <= 21'h1FAFF) ||
           (c >= 21'h20000 && c <= 21'h2FFFF) ||
           (c >= 21'hE0000 && c <= 21'hE01EF);
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_high   = (in_tdata[15:10] == 6'b110110);
  assign is_low    = (in_tdata[15:10] == 6'b110111);
  assign cp        = {1'b0, hi_r, in_tdata[9:0]} + 21'h10000;
  assign cp_emoji  = emoji_cp(cp);

  always_comb begin
    ev.brk   = 1'b0;
    ev.emo   = 1'b0;
    ev.last  = in_tlast;
    ev.start = pos_r - 16'd1;
    held_nxt = 1'b0;
    hi_nxt   = hi_r;
    if (held_r && is_low) begin
      ev.emo = cp_emoji;
      ev.brk = !cp_emoji;
    end else if (is_high && !in_tlast) begin
      // a lone held unit before this one is a non-emoji break
      ev.brk   = held_r;
      held_nxt = 1'b1;
      hi_nxt   = in_tdata[9:0];
    end else begin
      // bmp units and lone surrogates are never emoji
      ev.brk = 1'b1;
    end
    pos_nxt = in_tlast ? 16'd0 : pos_r + 16'd1;
  end

  assign q_ev   = ev;
  assign q_push = accept && (ev.brk || ev.emo || ev.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      pos_r  <= 16'd0;
    end else if (accept) begin
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/uem_fifo.sv -----
`default_nettype none
module uem_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire uem_pkg::ev_t push_ev,
  output logic              full,
  output logic              valid,
  input  wire logic         pop,
  output uem_pkg::ev_t      pop_ev
);

  localparam int unsigned PW = (uem_pkg::QDEPTH > 1) ? $clog2(uem_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(uem_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(uem_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(uem_pkg::QDEPTH);

  uem_pkg::ev_t  mem_r [uem_pkg::QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_ev  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PW'(1);
      if (do_pop)  rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_ev;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/uem_back.sv -----
`default_nettype none
module uem_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire uem_pkg::ev_t q_ev,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata,  // run_start[15:0], run_length[32:16], zero pad
  output logic              out_tlast   // row_done
);

  localparam int unsigned LW = uem_pkg::LEN_W;

  logic          run_r, run_nxt;
  logic [15:0]   start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovalid_r;
  logic [15:0]   ostart_r, res_start;
  logic [LW-1:0] olen_r, res_len;
  logic          olast_r;
  logic [LW:0]   sum;
  logic          closed, emit;

  assign q_pop = q_valid && (!ovalid_r || out_tready);

  always_comb begin
    run_nxt   = run_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    closed    = q_ev.brk && run_r;
    sum       = '0;
    if (q_ev.emo) begin
      if (!run_r) begin
        start_nxt = q_ev.start;
        sum       = (LW+1)'(2);
      end else begin
        sum = {1'b0, len_r} + (LW+1)'(2);
      end
      run_nxt = 1'b1;
      len_nxt = (sum > {1'b0, uem_pkg::LEN_CAP}) ? uem_pkg::LEN_CAP : sum[LW-1:0];
    end else if (closed) begin
      run_nxt   = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
    end
    priority if (closed) begin
      res_start = start_r;
      res_len   = len_r;
    end else if (run_nxt) begin
      res_start = start_nxt;
      res_len   = len_nxt;
    end else begin
      res_start = '0;
      res_len   = '0;
    end
    emit = closed || q_ev.last;
    // row end drops all run state
    if (q_ev.last) begin
      run_nxt   = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      start_r  <= '0;
      len_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        run_r   <= run_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
      end
      if (q_pop && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      ostart_r <= res_start;
      olen_r   <= res_len;
      olast_r  <= q_ev.last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, olen_r, ostart_r};
  assign out_tlast  = olast_r;

  a_mid_row_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> olen_r != '0)
    else $error("mid-row result with zero length");

  a_len_cap : assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> len_r <= uem_pkg::LEN_CAP && len_r != '0)
    else $error("open run length out of range");

  a_row_clear : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_ev.last |=> !run_r && out_tvalid && out_tlast)
    else $error("row end did not close state or give row-done result");

endmodule
`default_nettype wire

// ----- hdl/utf16_emoji_run_marker_top.sv -----
`default_nettype none
// UTF-16 emoji run marker. Takes one code unit per transaction on in_ (in_tlast on the
// row's last unit), joins surrogate pairs and reports each maximal run of emoji code
// points (0x1F000-0x1FAFF, 0x20000-0x2FFFF, 0xE0000-0xE01EF) as start position and
// length in code units. The row's last unit always gives one result with out_tlast
// set, of length zero when no run is pending. Sustained rate is one unit per clock while
// the output is not stalled: the front classifies a unit in the cycle it is taken,
// a four-entry queue decouples it from the back, whose run update feeds an output
// register. A unit's event is first written into the queue, then its result is registered.
module utf16_emoji_run_marker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // code_unit[15:0]
  input  wire logic        in_tlast,   // row_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // run_start[15:0], run_length[32:16], zero pad
  output logic             out_tlast   // row_done
);

  uem_pkg::ev_t push_ev, pop_ev;
  logic         push, full, qvalid, pop;

  uem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_ev      (push_ev)
  );

  uem_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .full    (full),
    .valid   (qvalid),
    .pop     (pop),
    .pop_ev  (pop_ev)
  );

  uem_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qvalid),
    .q_ev       (pop_ev),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
